// File: hw/rtl/mbrp_pkg.sv
// shared types, constants and crc function for the modbus reply parser
package mbrp_pkg;

	localparam logic [7:0] MB_ADDR = 8'h01;
	localparam logic [7:0] MB_FUNC = 8'h03;
	localparam logic [7:0] MB_COUNT = 8'h02;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [2:0] {
		PH_ADDR = 3'd0,
		PH_FUNC = 3'd1,
		PH_COUNT = 3'd2,
		PH_DATA_HI = 3'd3,
		PH_DATA_LO = 3'd4,
		PH_CRC_LO = 3'd5,
		PH_CRC_HI = 3'd6
	} phase_t;

	typedef struct packed {
		logic hit;
		logic [15:0] value;
	} frame_res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/modbus_single_register_reply_parser_top.sv
// top level of the modbus rtu single-register read reply parser
// Takes one received byte per request and emits the 16-bit data value of
// every 7-byte reply (address 0x01, function 0x03, count 0x02, data high,
// data low, crc low, crc high) whose crc-16 checks; bad headers restart the
// hunt and failed frames give nothing. One byte is taken every cycle while
// the input is not stalled: the byte is held in an input register, then a
// single pass of frame logic with an unrolled eight-bit crc update moves it
// into the result register. Input stalls only while a finished result is
// waiting and the output is stalled.
module modbus_single_register_reply_parser_top (
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	output logic rx_stall,
	input logic [7:0] rx_byte,
	output logic res_valid,
	input logic res_stall,
	output logic [15:0] distance_value
);
	import mbrp_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic free;
	logic advance;
	frame_res_t fres;

	assign advance = valid_s1 && free;
	assign rx_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	mbrp_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.take(advance),
		.rx_byte(byte_s1),
		.res(fres)
	);

	mbrp_result u_result (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && fres.hit),
		.value(fres.value),
		.free(free),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.distance_value(distance_value)
	);

endmodule

// File: hw/rtl/mbrp_frame.sv
// frame state machine with running crc-16 check
module mbrp_frame (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] rx_byte,
	output mbrp_pkg::frame_res_t res
);
	import mbrp_pkg::*;

	phase_t phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0] value_high_q, value_low_q, crc_low_q;
	logic [15:0] crc_next;

	assign crc_next = crc_byte(crc_q, rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			crc_q <= CRC_INIT;
		end else if (take) begin
			phase_q <= phase_d;
			crc_q <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (phase_q == PH_DATA_HI) begin
				value_high_q <= rx_byte;
			end
			if (phase_q == PH_DATA_LO) begin
				value_low_q <= rx_byte;
			end
			if (phase_q == PH_CRC_LO) begin
				crc_low_q <= rx_byte;
			end
		end
	end

	always_comb begin
		phase_d = PH_ADDR;
		crc_d = CRC_INIT;
		res.hit = 1'b0;
		res.value = {value_high_q, value_low_q};
		case (phase_q)
			PH_FUNC: begin
				if (rx_byte == MB_FUNC) begin
					phase_d = PH_COUNT;
					crc_d = crc_next;
				end
			end
			PH_COUNT: begin
				if (rx_byte == MB_COUNT) begin
					phase_d = PH_DATA_HI;
					crc_d = crc_next;
				end
			end
			PH_DATA_HI: begin
				phase_d = PH_DATA_LO;
				crc_d = crc_next;
			end
			PH_DATA_LO: begin
				phase_d = PH_CRC_LO;
				crc_d = crc_next;
			end
			PH_CRC_LO: begin
				phase_d = PH_CRC_HI;
				crc_d = crc_q;
			end
			PH_CRC_HI: begin
				res.hit = (crc_low_q == crc_q[7:0]) && (rx_byte == crc_q[15:8]);
			end
			default: begin
				if (rx_byte == MB_ADDR) begin
					phase_d = PH_FUNC;
					crc_d = crc_next;
				end
			end
		endcase
	end

endmodule

// File: hw/rtl/mbrp_result.sv
// result register toward the output channel
module mbrp_result (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [15:0] value,
	output logic free,
	output logic res_valid,
	input logic res_stall,
	output logic [15:0] distance_value
);
	logic valid_q;
	logic [15:0] value_q;

	assign free = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign distance_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			value_q <= value;
		end
	end

endmodule

// File: hw/rtl/mbrp_checker.sv
// port-level assertions for the reply parser and their binding
module mbrp_checker (
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	input logic rx_stall,
	input logic res_valid,
	input logic res_stall,
	input logic [15:0] distance_value
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(distance_value))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall)
		else $error("input stalled without a blocked result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && !rx_stall, 2))
		else $error("result without a request two cycles earlier");

	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall |=> !res_valid)
		else $error("results closer than one frame");

endmodule

bind modbus_single_register_reply_parser_top mbrp_checker u_chk (.*);

// File: tb/testbench.sv
// testbench for the modbus reply parser: directed frames, then random checked byte streams
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrp_pkg::*;

	localparam int DIRECTED_ROWS = 26;
	localparam int RANDOM_ITEMS = 1524;

	typedef enum logic [2:0] {
		SRC_RAW,
		SRC_CRC_LO,
		SRC_CRC_HI,
		SRC_BAD_CRC_LO,
		SRC_BAD_CRC_HI
	} byte_src_t;

	typedef enum logic [1:0] {
		EXP_PRED,
		EXP_NONE,
		EXP_VALUE
	} exp_kind_t;

	typedef enum logic [2:0] {
		FRAME_GOOD,
		FRAME_BAD_LO,
		FRAME_BAD_HI,
		FRAME_BREAK_FUNC,
		FRAME_BREAK_COUNT
	} frame_kind_t;

	typedef struct packed {
		byte_src_t src;
		logic [7:0] raw;
		exp_kind_t expect_kind;
		logic [15:0] value;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{SRC_RAW, MB_ADDR, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_FUNC, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_COUNT, EXP_NONE, 16'h0000},
		'{SRC_RAW, 8'h00, EXP_NONE, 16'h0000},
		'{SRC_RAW, 8'h00, EXP_NONE, 16'h0000},
		'{SRC_CRC_LO, 8'h00, EXP_NONE, 16'h0000},
		'{SRC_CRC_HI, 8'h00, EXP_VALUE, 16'h0000},
		'{SRC_RAW, MB_ADDR, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_FUNC, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_COUNT, EXP_NONE, 16'h0000},
		'{SRC_RAW, 8'hFF, EXP_NONE, 16'h0000},
		'{SRC_RAW, 8'hFF, EXP_NONE, 16'h0000},
		'{SRC_CRC_LO, 8'h00, EXP_NONE, 16'h0000},
		'{SRC_CRC_HI, 8'h00, EXP_VALUE, 16'hFFFF},
		// address then wrong function: the dropped byte does not start a frame
		'{SRC_RAW, MB_ADDR, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_ADDR, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_ADDR, EXP_NONE, 16'h0000},
		'{SRC_RAW, MB_FUNC, EXP_NONE, 16'h0000},
		'{SRC_RAW, 8'hFE, EXP_NONE, 16'h0000},
		// crc failure
		'{SRC_RAW, MB_ADDR, EXP_PRED, 16'h0000},
		'{SRC_RAW, MB_FUNC, EXP_PRED, 16'h0000},
		'{SRC_RAW, MB_COUNT, EXP_PRED, 16'h0000},
		'{SRC_RAW, 8'hA5, EXP_PRED, 16'h0000},
		'{SRC_RAW, 8'h5A, EXP_PRED, 16'h0000},
		'{SRC_BAD_CRC_LO, 8'h80, EXP_PRED, 16'h0000},
		'{SRC_CRC_HI, 8'h00, EXP_PRED, 16'h0000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [15:0] distance_value;

	phase_t model_phase = PH_ADDR;
	logic [15:0] model_crc = CRC_INIT;
	logic [7:0] model_hi = 8'h00;
	logic [7:0] model_lo = 8'h00;
	logic [7:0] model_crc_lo = 8'h00;

	logic [15:0] expected_values [$];
	logic [15:0] oldest_value;
	int mismatches = 0;
	int sent_count = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 83;

	modbus_single_register_reply_parser_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.distance_value(distance_value)
	);

	always #10 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic parse_byte(input logic [7:0] b, output logic [15:0] value);
		logic hit;
		hit = 1'b0;
		value = 16'h0000;
		case (model_phase)
			PH_FUNC: begin
				if (b == MB_FUNC) begin
					model_crc = crc16_step(model_crc, b);
					model_phase = PH_COUNT;
				end else begin
					model_crc = CRC_INIT;
					model_phase = PH_ADDR;
				end
			end
			PH_COUNT: begin
				if (b == MB_COUNT) begin
					model_crc = crc16_step(model_crc, b);
					model_phase = PH_DATA_HI;
				end else begin
					model_crc = CRC_INIT;
					model_phase = PH_ADDR;
				end
			end
			PH_DATA_HI: begin
				model_hi = b;
				model_crc = crc16_step(model_crc, b);
				model_phase = PH_DATA_LO;
			end
			PH_DATA_LO: begin
				model_lo = b;
				model_crc = crc16_step(model_crc, b);
				model_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				model_crc_lo = b;
				model_phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				hit = (model_crc_lo == model_crc[7:0]) && (b == model_crc[15:8]);
				value = {model_hi, model_lo};
				model_crc = CRC_INIT;
				model_phase = PH_ADDR;
			end
			default: begin
				model_crc = CRC_INIT;
				model_phase = PH_ADDR;
				if (b == MB_ADDR) begin
					model_crc = crc16_step(CRC_INIT, b);
					model_phase = PH_FUNC;
				end
			end
		endcase
		return hit;
	endfunction

	task automatic send_request(input byte_src_t src, input logic [7:0] raw,
			input exp_kind_t expect_kind, input logic [15:0] typed_value);
		logic [7:0] b;
		logic hit;
		logic [15:0] value;
		case (src)
			SRC_CRC_LO: b = model_crc[7:0];
			SRC_CRC_HI: b = model_crc[15:8];
			SRC_BAD_CRC_LO: b = model_crc[7:0] ^ raw;
			SRC_BAD_CRC_HI: b = model_crc[15:8] ^ raw;
			default: b = raw;
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall !== 1'b0);
		hit = parse_byte(b, value);
		case (expect_kind)
			EXP_NONE: ;
			EXP_VALUE: expected_values.push_back(typed_value);
			default: if (hit) expected_values.push_back(value);
		endcase
		sent_count++;
	endtask

	function automatic logic [7:0] data_byte();
		logic [7:0] corners [4];
		corners = '{8'h00, 8'hFF, MB_ADDR, MB_FUNC};
		if ($urandom_range(3) == 0) begin
			return corners[2'($urandom_range(3))];
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic send_frame(input frame_kind_t kind);
		logic [7:0] wrong;
		logic [7:0] mask;
		mask = 8'($urandom_range(255, 1));
		send_request(SRC_RAW, MB_ADDR, EXP_PRED, 16'h0000);
		if (kind == FRAME_BREAK_FUNC) begin
			do wrong = 8'($urandom_range(255)); while (wrong == MB_FUNC);
			send_request(SRC_RAW, wrong, EXP_PRED, 16'h0000);
			return;
		end
		send_request(SRC_RAW, MB_FUNC, EXP_PRED, 16'h0000);
		if (kind == FRAME_BREAK_COUNT) begin
			do wrong = 8'($urandom_range(255)); while (wrong == MB_COUNT);
			send_request(SRC_RAW, wrong, EXP_PRED, 16'h0000);
			return;
		end
		send_request(SRC_RAW, MB_COUNT, EXP_PRED, 16'h0000);
		send_request(SRC_RAW, data_byte(), EXP_PRED, 16'h0000);
		send_request(SRC_RAW, data_byte(), EXP_PRED, 16'h0000);
		if (kind == FRAME_BAD_LO) begin
			send_request(SRC_BAD_CRC_LO, mask, EXP_PRED, 16'h0000);
		end else begin
			send_request(SRC_CRC_LO, 8'h00, EXP_PRED, 16'h0000);
		end
		if (kind == FRAME_BAD_HI) begin
			send_request(SRC_BAD_CRC_HI, mask, EXP_PRED, 16'h0000);
		end else begin
			send_request(SRC_CRC_HI, 8'h00, EXP_PRED, 16'h0000);
		end
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected distance_value, expected none, actual %h",
					$time, distance_value);
				mismatches++;
			end else begin
				oldest_value = expected_values.pop_front();
				if (distance_value !== oldest_value) begin
					$display("%0t: distance_value expected %h actual %h",
						$time, oldest_value, distance_value);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int pick;
		int random_sent;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_request(DIRECTED[i].src, DIRECTED[i].raw, DIRECTED[i].expect_kind,
				DIRECTED[i].value);
		end
		while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
			random_sent = sent_count - DIRECTED_ROWS;
			if (random_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 6;
				recv_idle_pct = 83;
			end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 83;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(99);
			if (pick < 65) begin
				send_frame(FRAME_GOOD);
			end else if (pick < 72) begin
				send_frame(FRAME_BAD_LO);
			end else if (pick < 80) begin
				send_frame(FRAME_BAD_HI);
			end else if (pick < 85) begin
				send_frame(FRAME_BREAK_FUNC);
			end else if (pick < 90) begin
				send_frame(FRAME_BREAK_COUNT);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					send_request(SRC_RAW, 8'($urandom_range(255)), EXP_PRED, 16'h0000);
				end
			end
		end
		rx_valid <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
